### hw/rtl/iol_pkg.sv
// Shared types and codes for the indexed ordered list.
`default_nettype none

package iol_pkg;

  typedef enum logic [2:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_BACK   = 3'd1,
    OP_TAKE_FRONT = 3'd2,
    OP_TAKE_BACK  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_FIND       = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPORT
  } state_t;

  // what every cell in the row does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_OPEN,   // cells at or above the mark move up, the marked cell loads
    CMD_CLOSE   // cells at or above the mark take their upper neighbour
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      probe;  // search token walks one cell on
  } cell_ctrl_t;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

endpackage

`default_nettype wire

### hw/rtl/iol_ifs.sv
// Request and response channel interfaces of the indexed ordered list.
`default_nettype none

interface iol_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [4:0]  position;
  logic [31:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface iol_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  found_index;
  logic [4:0]  entry_count;
  logic [31:0] front_value;
  logic [31:0] back_value;
  logic        is_empty;

  modport source (output valid, output status, output found_index, output entry_count,
                  output front_value, output back_value, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input found_index, input entry_count,
                  input front_value, input back_value, input is_empty,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/indexed_ordered_list.sv
// Top level of the indexed ordered list: control sequencer over a row of cells.
`default_nettype none

//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  req     | in  | valid / ready | opcode, position, item_value
//  rsp     | out | valid / ready | status, found_index, entry_count,
//          |     |               | front_value, back_value, is_empty
//
//  Push, pop, insert and remove shift the row on the accept edge; the result
//  register loads from the report step once the output is free. Find walks a
//  token along the row, one cell a cycle, to a match or past the last entry.
//  One item is in work at a time; the next is taken while the previous result
//  still waits in the output register, and a stalled rsp holds back only the
//  report step. rst (synchronous) clears the count, tokens and output valid.

module indexed_ordered_list_core #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire       clk,
  input  wire       rst,
  iol_in_if.sink    req,
  iol_out_if.source rsp
);
  import iol_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // ---------------------------------------------------------------------------
  // registers
  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [CNT_W-1:0]      idx, idx_next;          // cell the search token sits on
  logic [DATA_WIDTH-1:0] key, key_next;
  status_t               res_status, status_next;
  logic [CNT_W-1:0]      res_fidx, fidx_next;

  logic                  out_valid;
  status_t               out_status;
  logic [COUNT_W-1:0]    out_fidx;
  logic [COUNT_W-1:0]    out_count;
  logic [VALUE_W-1:0]    out_front;
  logic [VALUE_W-1:0]    out_back;
  logic                  out_empty;

  // ---------------------------------------------------------------------------
  // request decode
  op_t                   op;
  logic                  acc;
  logic [CMP_W-1:0]      pos_x, count_x;
  logic                  pos_lt;                 // position names a stored entry
  logic [IDX_W-1:0]      pos_at, count_at, tail_at;
  logic [CNT_W-1:0]      count_m1;
  logic                  full, empty;
  logic [DATA_WIDTH+VALUE_W-1:0] val_wide;
  logic [DATA_WIDTH-1:0] val_in;

  assign op        = op_t'(req.opcode);
  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid & req.ready;

  assign pos_x    = CMP_W'(req.position);
  assign count_x  = CMP_W'(count);
  assign pos_lt   = pos_x < count_x;
  assign pos_at   = pos_x[IDX_W-1:0];
  assign count_at = count[IDX_W-1:0];
  assign count_m1 = count - CNT_W'(1);
  assign tail_at  = count_m1[IDX_W-1:0];
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // value bits above DATA_WIDTH are dropped
  assign val_wide = {{DATA_WIDTH{1'b0}}, req.item_value};
  assign val_in   = val_wide[DATA_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // cell row
  cell_ctrl_t            ctrl;
  logic [IDX_W-1:0]      at;
  logic                  find_start;
  logic [DATA_WIDTH-1:0] vals [CAPACITY];
  logic [DATA_WIDTH-1:0] taps [CAPACITY];
  logic [CAPACITY-1:0]   tokens;
  logic [CAPACITY-1:0]   hits;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_v, right_v;
    logic                  tok_in;

    if (g == 0) begin : g_first
      assign left_v = '0;
      assign tok_in = find_start;
    end else begin : g_mid
      assign left_v = vals[g-1];
      assign tok_in = tokens[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = vals[g+1];
    end

    iol_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .at        (at),
      .tail      (tail_at),
      .load_val  (val_in),
      .left_val  (left_v),
      .right_val (right_v),
      .key       (key),
      .token_in  (tok_in),
      .val       (vals[g]),
      .token     (tokens[g]),
      .hit       (hits[g]),
      .tap       (taps[g])
    );
  end

  // back value: only the cell at count-1 drives its tap
  logic [DATA_WIDTH-1:0] back_d;
  always_comb begin
    back_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_d = back_d | taps[i];
    end
  end

  logic hit_any, search_end, search_done;
  assign hit_any     = |hits;
  assign search_end  = (idx == count);   // token has passed the last entry
  assign search_done = search_end | hit_any;

  logic out_load;
  assign out_load = (state == S_REPORT) & (~out_valid | rsp.ready);

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = (op == OP_FIND) ? S_SEARCH : S_REPORT;
        end
      end
      S_SEARCH: begin
        if (search_done) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // row commands and result bookkeeping
  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.probe  = 1'b0;
    at          = '0;
    find_start  = 1'b0;
    count_next  = count;
    idx_next    = idx;
    key_next    = key;
    status_next = res_status;
    fidx_next   = res_fidx;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          status_next = ST_OK;
          fidx_next   = '0;
          unique case (op) inside
            OP_ADD_FRONT, OP_ADD_BACK, OP_INSERT: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                ctrl.cmd   = CMD_OPEN;
                count_next = count + CNT_W'(1);
                if (op == OP_ADD_FRONT) begin
                  at = '0;
                end else if (op == OP_INSERT && pos_lt) begin
                  at = pos_at;
                end else begin
                  at = count_at;        // append; insert past the end clamps here
                end
              end
            end
            OP_TAKE_FRONT, OP_TAKE_BACK: begin
              if (empty) begin
                status_next = ST_BAD;
              end else begin
                ctrl.cmd   = CMD_CLOSE;
                count_next = count_m1;
                at         = (op == OP_TAKE_FRONT) ? '0 : tail_at;
              end
            end
            OP_REMOVE: begin
              if (!pos_lt) begin
                status_next = ST_BAD;
              end else begin
                ctrl.cmd   = CMD_CLOSE;
                count_next = count_m1;
                at         = pos_at;
              end
            end
            OP_FIND: begin
              key_next   = val_in;
              ctrl.probe = 1'b1;
              find_start = 1'b1;
              idx_next   = '0;
            end
            default: ;                  // unused code: no change, ok
          endcase
        end
      end
      S_SEARCH: begin
        if (search_end) begin
          status_next = ST_NOT_FOUND;
          fidx_next   = count;
        end else if (hit_any) begin
          status_next = ST_OK;
          fidx_next   = idx;
        end else begin
          ctrl.probe = 1'b1;
          idx_next   = idx + CNT_W'(1);
        end
      end
      S_REPORT: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    res_status <= status_next;
    res_fidx   <= fidx_next;
  end

  // output register
  logic [DATA_WIDTH+VALUE_W-1:0] front_wide, back_wide;
  logic [CNT_W+COUNT_W-1:0]      count_wide, fidx_wide;

  assign front_wide = {{VALUE_W{1'b0}}, vals[0]};
  assign back_wide  = {{VALUE_W{1'b0}}, back_d};
  assign count_wide = {{COUNT_W{1'b0}}, count};
  assign fidx_wide  = {{COUNT_W{1'b0}}, res_fidx};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_fidx   <= fidx_wide[COUNT_W-1:0];
      out_count  <= count_wide[COUNT_W-1:0];
      out_front  <= empty ? '0 : front_wide[VALUE_W-1:0];
      out_back   <= empty ? '0 : back_wide[VALUE_W-1:0];
      out_empty  <= empty;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_fidx;
  assign rsp.entry_count = out_count;
  assign rsp.front_value = out_front;
  assign rsp.back_value  = out_back;
  assign rsp.is_empty    = out_empty;

  // ---------------------------------------------------------------------------
  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tokens))
    else $error("more than one search token in the row");

  a_update_reports: assert property (@(posedge clk) disable iff (rst)
    acc && (op != OP_FIND) |=> state == S_REPORT)
    else $error("update item did not go straight to report");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_search_token: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) && !search_end |-> $onehot(tokens))
    else $error("search running without a token in the row");

endmodule

`default_nettype wire

### hw/rtl/iol_cell.sv
// One storage cell of the list row: shifts, loads, compares, carries the search token.
`default_nettype none

module iol_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  wire                     clk,
  input  wire                     rst,
  input  iol_pkg::cell_ctrl_t     ctrl,
  input  wire  [IDX_W-1:0]        at,
  input  wire  [IDX_W-1:0]        tail,
  input  wire  [DATA_WIDTH-1:0]   load_val,
  input  wire  [DATA_WIDTH-1:0]   left_val,
  input  wire  [DATA_WIDTH-1:0]   right_val,
  input  wire  [DATA_WIDTH-1:0]   key,
  input  wire                     token_in,
  output logic [DATA_WIDTH-1:0]   val,
  output logic                    token,
  output logic                    hit,
  output logic [DATA_WIDTH-1:0]   tap
);
  import iol_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.cmd)
      CMD_OPEN: begin
        if (ME > at) begin
          val_next = left_val;
        end else if (ME == at) begin
          val_next = load_val;
        end
      end
      CMD_CLOSE: begin
        if (ME >= at) begin
          val_next = right_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else begin
      token <= ctrl.probe & token_in;
    end
  end

  assign hit = token & (val == key);
  assign tap = (ME == tail) ? val : '0;

endmodule

`default_nettype wire
